[hdl/rrbgp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbgp_pkg
// Shared types and constants for the round-robin bus grant pacer.
// ----------------------------------------------------------------------------
package rrbgp_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CHAN_W       = 4;
    localparam int CNT_W        = 5;
    localparam int DVD_W        = 36;
    localparam int DSR_W        = 32;
    localparam int STEP_W       = 6;

    localparam logic [19:0]       US_PER_S  = 20'd1000000;
    localparam logic [STEP_W-1:0] MOD_STEPS = 6'd4;
    localparam logic [STEP_W-1:0] DIV_STEPS = 6'd36;

    typedef enum logic [1:0] {
        ST_GRANT   = 2'd0,
        ST_BUSY    = 2'd1,
        ST_NONE    = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_CHANNELS   = 2'd0,
        CFG_WIRE_BYTES = 2'd1,
        CFG_HOST_BYTES = 2'd2,
        CFG_BANDWIDTH  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_MODW,
        S_PICK,
        S_MUL,
        S_DIV,
        S_DIVW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic              found;
        logic [CHAN_W-1:0] chan;
    } t_pick;

endpackage

[hdl/rrbgp_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbgp_divider
// Shared restoring divider, one quotient bit per cycle, dividend taken from
// the top bit downwards for a programmable number of steps.
// ----------------------------------------------------------------------------
module rrbgp_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrbgp_pkg::t_div_req i_req,
    output rrbgp_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [rrbgp_pkg::STEP_W-1:0] r_cnt;
    logic [rrbgp_pkg::DVD_W-1:0]  r_dvd;
    logic [rrbgp_pkg::DSR_W-1:0]  r_dsr;
    logic [rrbgp_pkg::DSR_W-1:0]  r_rem;

    logic [rrbgp_pkg::DSR_W:0]    trial;
    logic                         fits;
    logic [rrbgp_pkg::DSR_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_dvd[rrbgp_pkg::DVD_W-1]};
        fits  = trial >= {1'b0, r_dsr};
        diff  = trial - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == rrbgp_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.steps;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - rrbgp_pkg::STEP_W'(1);
            // quotient bits shift in behind the dividend
            r_dvd <= {r_dvd[rrbgp_pkg::DVD_W-2:0], fits};
            r_rem <= fits ? diff[rrbgp_pkg::DSR_W-1:0] : trial[rrbgp_pkg::DSR_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

[hdl/rrbgp_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbgp_scan
// Round-robin picker: first ready channel at or after the start position,
// wrapping round to the lowest ready channel below the channel count.
// ----------------------------------------------------------------------------
module rrbgp_scan (
    input  logic [rrbgp_pkg::MAX_CHANNELS-1:0] i_mask,
    input  logic [rrbgp_pkg::CNT_W-1:0]        i_count,
    input  logic [rrbgp_pkg::CHAN_W-1:0]       i_start,
    output rrbgp_pkg::t_pick                   o_pick
);

    logic [rrbgp_pkg::MAX_CHANNELS-1:0] live;
    logic [rrbgp_pkg::MAX_CHANNELS-1:0] upper;

    always_comb begin
        live   = '0;
        upper  = '0;
        o_pick = '0;
        for (int i = 0; i < rrbgp_pkg::MAX_CHANNELS; i++) begin
            live[i]  = i_mask[i] && (rrbgp_pkg::CNT_W'(i) < i_count);
            upper[i] = live[i] && (rrbgp_pkg::CHAN_W'(i) >= i_start);
        end
        // lowest live channel, used when nothing sits at or above the start
        for (int i = rrbgp_pkg::MAX_CHANNELS - 1; i >= 0; i--) begin
            if (live[i]) begin
                o_pick.found = 1'b1;
                o_pick.chan  = rrbgp_pkg::CHAN_W'(i);
            end
        end
        if (upper != '0) begin
            for (int i = rrbgp_pkg::MAX_CHANNELS - 1; i >= 0; i--) begin
                if (upper[i]) begin
                    o_pick.chan = rrbgp_pkg::CHAN_W'(i);
                end
            end
        end
    end

endmodule

[hdl/round_robin_bus_grant_pacer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_bus_grant_pacer
// Round-robin bus arbiter with transfer-time pacing; one result per item.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready    | i_sim_time, i_ready_mask, i_out_full
//  out      | o_out_valid / i_out_ready  | o_status, o_channel, o_bytes_moved,
//           |                            | o_push_bytes, o_next_event
//  cfg      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// a busy bus or zero channels goes from the check straight to the result; a scan
// runs the pointer wrap and a grant with nonzero bandwidth the transfer time on the
// shared divider: one bit a cycle, 4 steps for the pointer wrap, 36 for the time.
// one item is in work at a time; the output register lets the next item in
// while a result waits. reset is synchronous and clears pointer and busy time.
// ----------------------------------------------------------------------------
module round_robin_bus_grant_pacer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_sim_time,
    input  logic [15:0] i_ready_mask,
    input  logic        i_out_full,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_channel,
    output logic [15:0] o_bytes_moved,
    output logic [15:0] o_push_bytes,
    output logic [63:0] o_next_event
);

    // configuration
    logic [rrbgp_pkg::CNT_W-1:0] r_cin;
    logic [15:0]                 r_wire;
    logic [15:0]                 r_host;
    logic [31:0]                 r_bw;

    // persistent state
    logic [rrbgp_pkg::CHAN_W-1:0] r_ptr;
    logic [63:0]                  r_busy_until;

    // item in work
    rrbgp_pkg::t_state            r_state;
    rrbgp_pkg::t_state            n_state;
    logic [63:0]                  r_now;
    logic [15:0]                  r_mask;
    logic                         r_full;
    logic [rrbgp_pkg::CNT_W-1:0]  r_n;
    logic [rrbgp_pkg::CHAN_W-1:0] r_start;
    rrbgp_pkg::t_status           r_status;
    logic [rrbgp_pkg::CHAN_W-1:0] r_chan;
    logic [rrbgp_pkg::DVD_W-1:0]  r_prod;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [3:0]  r_out_chan;
    logic [15:0] r_out_moved;
    logic [15:0] r_out_push;
    logic [63:0] r_out_next;

    logic [rrbgp_pkg::CNT_W-1:0] n_eff;
    logic                        bus_busy;
    logic                        grant;
    logic                        out_load;
    rrbgp_pkg::t_div_req         div_req;
    rrbgp_pkg::t_div_rsp         div_rsp;
    rrbgp_pkg::t_pick            pick;

    rrbgp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rrbgp_scan u_scan (
        .i_mask  (r_mask),
        .i_count (r_n),
        .i_start (r_start),
        .o_pick  (pick)
    );

    assign n_eff    = (r_cin > rrbgp_pkg::CNT_W'(rrbgp_pkg::MAX_CHANNELS))
                    ? rrbgp_pkg::CNT_W'(rrbgp_pkg::MAX_CHANNELS) : r_cin;
    assign bus_busy = r_busy_until > r_now;
    assign grant    = pick.found && !r_full;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrbgp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rrbgp_pkg::S_CHECK;
                end
            end
            rrbgp_pkg::S_CHECK: begin
                if (bus_busy || n_eff == '0) begin
                    n_state = rrbgp_pkg::S_DONE;
                end else begin
                    n_state = rrbgp_pkg::S_MOD;
                end
            end
            rrbgp_pkg::S_MOD:  n_state = rrbgp_pkg::S_MODW;
            rrbgp_pkg::S_MODW: begin
                if (div_rsp.done) begin
                    n_state = rrbgp_pkg::S_PICK;
                end
            end
            rrbgp_pkg::S_PICK: begin
                if (grant && r_bw != '0) begin
                    n_state = rrbgp_pkg::S_MUL;
                end else begin
                    n_state = rrbgp_pkg::S_DONE;
                end
            end
            rrbgp_pkg::S_MUL:  n_state = rrbgp_pkg::S_DIV;
            rrbgp_pkg::S_DIV:  n_state = rrbgp_pkg::S_DIVW;
            rrbgp_pkg::S_DIVW: begin
                if (div_rsp.done) begin
                    n_state = rrbgp_pkg::S_DONE;
                end
            end
            rrbgp_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = rrbgp_pkg::S_IDLE;
                end
            end
            default: n_state = rrbgp_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready       = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_bw;
        div_req.steps    = rrbgp_pkg::DIV_STEPS;
        case (r_state)
            rrbgp_pkg::S_IDLE: o_in_ready = i_rst_n;
            rrbgp_pkg::S_MOD: begin
                // pointer modulo channel count, pointer in the top bits
                div_req.start    = 1'b1;
                div_req.dividend = {r_ptr, {(rrbgp_pkg::DVD_W - rrbgp_pkg::CHAN_W){1'b0}}};
                div_req.divisor  = rrbgp_pkg::DSR_W'(r_n);
                div_req.steps    = rrbgp_pkg::MOD_STEPS;
            end
            rrbgp_pkg::S_DIV:  div_req.start = 1'b1;
            rrbgp_pkg::S_DONE: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrbgp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cin  <= rrbgp_pkg::CNT_W'(rrbgp_pkg::MAX_CHANNELS);
            r_wire <= 16'd1;
            r_host <= '0;
            r_bw   <= '0;
        end else if (i_cfg_we) begin
            case (rrbgp_pkg::t_cfg_idx'(i_cfg_idx))
                rrbgp_pkg::CFG_CHANNELS:   r_cin  <= i_cfg_data[rrbgp_pkg::CNT_W-1:0];
                rrbgp_pkg::CFG_WIRE_BYTES: r_wire <= i_cfg_data[15:0];
                rrbgp_pkg::CFG_HOST_BYTES: r_host <= i_cfg_data[15:0];
                rrbgp_pkg::CFG_BANDWIDTH:  r_bw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_busy_until <= '0;
        end else begin
            if (r_state == rrbgp_pkg::S_PICK && grant) begin
                r_ptr <= (rrbgp_pkg::CNT_W'(pick.chan) + rrbgp_pkg::CNT_W'(1) == r_n)
                       ? '0 : pick.chan + rrbgp_pkg::CHAN_W'(1);
            end
            if (r_state == rrbgp_pkg::S_DIVW && div_rsp.done && div_rsp.quot != '0) begin
                r_busy_until <= r_now + 64'(div_rsp.quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rrbgp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_now  <= i_sim_time;
                    r_mask <= i_ready_mask;
                    r_full <= i_out_full;
                end
            end
            rrbgp_pkg::S_CHECK: begin
                r_n      <= n_eff;
                r_chan   <= '0;
                r_status <= bus_busy ? rrbgp_pkg::ST_BUSY : rrbgp_pkg::ST_NONE;
            end
            rrbgp_pkg::S_MODW: begin
                if (div_rsp.done) begin
                    r_start <= div_rsp.rem[rrbgp_pkg::CHAN_W-1:0];
                end
            end
            rrbgp_pkg::S_PICK: begin
                if (grant) begin
                    r_status <= rrbgp_pkg::ST_GRANT;
                    r_chan   <= pick.chan;
                end else if (pick.found) begin
                    r_status <= rrbgp_pkg::ST_REFUSED;
                end
            end
            rrbgp_pkg::S_MUL: begin
                r_prod <= rrbgp_pkg::DVD_W'(r_wire)
                        * rrbgp_pkg::DVD_W'(rrbgp_pkg::US_PER_S);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_chan   <= r_chan;
            r_out_moved  <= (r_status == rrbgp_pkg::ST_GRANT) ? r_wire : '0;
            r_out_push   <= (r_status == rrbgp_pkg::ST_GRANT) ? r_host : '0;
            r_out_next   <= (r_bw != '0 && bus_busy) ? r_busy_until : '1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_channel     = r_out_chan;
    assign o_bytes_moved = r_out_moved;
    assign o_push_bytes  = r_out_push;
    assign o_next_event  = r_out_next;

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_ptr_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrbgp_pkg::S_PICK && grant) |=> ({1'b0, r_ptr} < r_n))
        else $error("pointer left outside channel count after grant");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rrbgp_pkg::S_DIVW) |=> $stable(r_busy_until))
        else $error("busy time changed outside transfer update");

    a_grant_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrbgp_pkg::S_DONE && r_status == rrbgp_pkg::ST_GRANT)
        |-> ({1'b0, r_chan} < r_n))
        else $error("granted channel beyond channel count");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin bus grant pacer. A short table of
// events and register writes covers the extremes first, then random events
// run under changing register settings and handshake idling. Every result is
// checked field by field against a table entry or a local model of the pointer and busy time.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SEG_ITEMS   = 46;
    localparam logic [63:0] NO_EVT      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] T_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic        ROW_EVT     = 1'b0;
    localparam logic        ROW_CFG     = 1'b1;

    typedef struct packed {
        rrbgp_pkg::t_status status;
        logic [3:0]         chan;
        logic [15:0]        moved;
        logic [15:0]        pushed;
        logic [63:0]        next_ev;
    } t_grant_res;

    typedef struct packed {
        logic                kind;
        rrbgp_pkg::t_cfg_idx idx;
        logic [31:0]         data;
        logic [63:0]         now;
        logic [15:0]         mask;
        logic                full;
        logic                fixed;
        t_grant_res          res;
    } t_dir_row;

    localparam t_grant_res NO_RES    = '{rrbgp_pkg::ST_NONE, 4'd0, 16'd0, 16'd0, 64'd0};
    localparam t_grant_res R_NONE    = '{rrbgp_pkg::ST_NONE, 4'd0, 16'd0, 16'd0, NO_EVT};
    localparam t_grant_res R_REFUSED = '{rrbgp_pkg::ST_REFUSED, 4'd0, 16'd0, 16'd0, NO_EVT};

    localparam int N_DIR = 29;
    // after reset: 16 channels, 1 wire byte, 0 host bytes, no pacing
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd0, 16'h0000, 1'b0, 1'b1, R_NONE},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd5, 16'h0001, 1'b1, 1'b1, R_REFUSED},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd5, 16'h8000, 1'b0, 1'b1,
          '{rrbgp_pkg::ST_GRANT, 4'd15, 16'd1, 16'd0, NO_EVT}},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd6, 16'hFFFF, 1'b0, 1'b1,
          '{rrbgp_pkg::ST_GRANT, 4'd0, 16'd1, 16'd0, NO_EVT}},
        '{ROW_CFG, rrbgp_pkg::CFG_HOST_BYTES, 32'h0000_FFFF, 64'd0, 16'h0, 1'b0, 1'b0,
          NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_WIRE_BYTES, 32'h0000_FFFF, 64'd0, 16'h0, 1'b0, 1'b0,
          NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_BANDWIDTH, 32'd1, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd100, 16'hFFFF, 1'b1, 1'b1, R_REFUSED},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd100, 16'hFFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd200, 16'h0000, 1'b1, 1'b0, NO_RES},
        // busy time wraps past the top of the 64-bit range
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'hFFFF_FFFF_FFFF_FFF0, 16'h0004,
          1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd0, 16'hFFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_BANDWIDTH, 32'hFFFF_FFFF, 64'd0, 16'h0, 1'b0, 1'b0,
          NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'h0008, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_WIRE_BYTES, 32'd0, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'h0010, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'hFFFF, 1'b0, 1'b1, R_NONE},
        '{ROW_CFG, rrbgp_pkg::CFG_CHANNELS, 32'd31, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'h0001, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_WIRE_BYTES, 32'd1, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'h0400, 1'b0, 1'b0, NO_RES},
        // pointer left at 11 with only 3 channels in the round
        '{ROW_CFG, rrbgp_pkg::CFG_CHANNELS, 32'd3, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'hFFF8, 1'b0, 1'b1, R_NONE},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, T_MAX, 16'hFFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, rrbgp_pkg::CFG_CHANNELS, 32'd1, 64'd0, 16'h0, 1'b0, 1'b0, NO_RES},
        // bus still busy until 14: mask and full are ignored
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd0, 16'h0001, 1'b1, 1'b1,
          '{rrbgp_pkg::ST_BUSY, 4'd0, 16'd0, 16'd0, 64'd14}},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd0, 64'd14, 16'h0001, 1'b0, 1'b0, NO_RES},
        '{ROW_EVT, rrbgp_pkg::CFG_CHANNELS, 32'd20, 64'd20, 16'hFFFE, 1'b0, 1'b1, R_NONE}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_idx    = '0;
    logic [31:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_sim_time   = '0;
    logic [15:0] i_ready_mask = '0;
    logic        i_out_full   = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_channel;
    logic [15:0] o_bytes_moved;
    logic [15:0] o_push_bytes;
    logic [63:0] o_next_event;

    // model of the register file and the arbiter state
    logic [4:0]  cfg_chan        = 5'd16;
    logic [15:0] cfg_wire        = 16'd1;
    logic [15:0] cfg_host        = 16'd0;
    logic [31:0] cfg_bw          = 32'd0;
    logic [3:0]  pace_rr_ptr     = 4'd0;
    logic [63:0] pace_busy_until = 64'd0;

    t_grant_res grant_exp_q [$];
    int         err_cnt       = 0;
    int         cyc_cnt       = 0;
    int         send_idle_pct = 10;
    int         recv_idle_pct = 30;
    logic       hold_req      = 1'b0;
    int         hold_cnt      = 0;

    round_robin_bus_grant_pacer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sim_time    (i_sim_time),
        .i_ready_mask  (i_ready_mask),
        .i_out_full    (i_out_full),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_channel     (o_channel),
        .o_bytes_moved (o_bytes_moved),
        .o_push_bytes  (o_push_bytes),
        .o_next_event  (o_next_event)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_grant_res predict_grant(input logic [63:0] now,
                                                 input logic [15:0] mask,
                                                 input logic full);
        t_grant_res  r;
        int          n;
        int          c;
        int          k;
        logic        stop;
        logic [63:0] xfer;
        r    = NO_RES;
        stop = 1'b0;
        n    = (cfg_chan > rrbgp_pkg::MAX_CHANNELS) ? rrbgp_pkg::MAX_CHANNELS
                                                    : int'(cfg_chan);
        if (pace_busy_until > now) begin
            r.status = rrbgp_pkg::ST_BUSY;
        end else begin
            for (k = 0; k < n && !stop; k++) begin
                c = (int'(pace_rr_ptr) + k) % n;
                if (mask[c]) begin
                    stop = 1'b1;
                    if (full) begin
                        r.status = rrbgp_pkg::ST_REFUSED;
                    end else begin
                        r.status    = rrbgp_pkg::ST_GRANT;
                        r.chan      = 4'(c);
                        r.moved     = cfg_wire;
                        r.pushed    = cfg_host;
                        pace_rr_ptr = 4'((c + 1) % n);
                        if (cfg_bw != 0) begin
                            xfer = (64'(cfg_wire) * 64'd1000000) / 64'(cfg_bw);
                            if (xfer != 0) pace_busy_until = now + xfer;
                        end
                    end
                end
            end
        end
        r.next_ev = (cfg_bw != 0 && pace_busy_until > now) ? pace_busy_until : NO_EVT;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // receiver: checks each result, then decides ready for the next cycle
    always @(posedge i_clk) begin
        t_grant_res exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grant_exp_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result with nothing expected, expected none, got status %0d",
                         $time, o_status);
            end else begin
                exp_r = grant_exp_q.pop_front();
                cmp_field("status", 64'(exp_r.status), 64'(o_status));
                cmp_field("channel", 64'(exp_r.chan), 64'(o_channel));
                cmp_field("bytes_moved", 64'(exp_r.moved), 64'(o_bytes_moved));
                cmp_field("push_bytes", 64'(exp_r.pushed), 64'(o_push_bytes));
                cmp_field("next_event", exp_r.next_ev, o_next_event);
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_cnt    <= HOLD_CYCLES;
            hold_req    <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input rrbgp_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rrbgp_pkg::CFG_CHANNELS:   cfg_chan = data[4:0];
            rrbgp_pkg::CFG_WIRE_BYTES: cfg_wire = data[15:0];
            rrbgp_pkg::CFG_HOST_BYTES: cfg_host = data[15:0];
            rrbgp_pkg::CFG_BANDWIDTH:  cfg_bw   = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offers one item and records its expected result once it is taken
    task automatic push_event(input logic [63:0] now, input logic [15:0] mask,
                              input logic full, input logic fixed,
                              input t_grant_res fixed_res);
        t_grant_res exp_r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_sim_time   <= now;
        i_ready_mask <= mask;
        i_out_full   <= full;
        do @(posedge i_clk); while (!o_in_ready);
        exp_r = predict_grant(now, mask, full);
        grant_exp_q.push_back(fixed ? fixed_res : exp_r);
    endtask

    // drain all results so the block is idle before a register write
    task automatic settle;
        i_in_valid <= 1'b0;
        while (grant_exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int          p;
        int          s;
        int          i;
        int          r;
        logic [63:0] sim_clock;
        logic [63:0] xfer_est;
        logic [15:0] mask_v;
        logic [4:0]  ch_v;
        logic [15:0] wire_v;
        logic [15:0] host_v;
        logic [31:0] bw_v;
        int          send_pct [3] = '{23, 82, 0};
        int          recv_pct [3] = '{82, 23, 0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                settle();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                push_event(DIR_ROWS[i].now, DIR_ROWS[i].mask, DIR_ROWS[i].full,
                           DIR_ROWS[i].fixed, DIR_ROWS[i].res);
            end
        end
        settle();

        sim_clock = 64'd0;
        for (p = 0; p < 3; p++) begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (s = 0; s < 4; s++) begin
                case ($urandom_range(0, 7))
                    0:       ch_v = 5'd0;
                    1:       ch_v = 5'd1;
                    2:       ch_v = 5'd16;
                    3:       ch_v = 5'($urandom_range(17, 31));
                    default: ch_v = 5'($urandom_range(2, 15));
                endcase
                case ($urandom_range(0, 5))
                    0:       wire_v = 16'd0;
                    1:       wire_v = 16'd1;
                    2:       wire_v = 16'hFFFF;
                    default: wire_v = 16'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       host_v = 16'd0;
                    1:       host_v = 16'hFFFF;
                    default: host_v = 16'($urandom);
                endcase
                case ($urandom_range(0, 6))
                    0:       bw_v = 32'd0;
                    1:       bw_v = 32'd1;
                    2:       bw_v = 32'hFFFF_FFFF;
                    3:       bw_v = $urandom_range(1, 1000);
                    4:       bw_v = $urandom_range(1000, 1000000);
                    default: bw_v = $urandom;
                endcase
                // unused upper data bits carry junk
                write_reg(rrbgp_pkg::CFG_CHANNELS, ($urandom & 32'hFFFF_FFE0) | 32'(ch_v));
                write_reg(rrbgp_pkg::CFG_WIRE_BYTES,
                          ($urandom & 32'hFFFF_0000) | 32'(wire_v));
                write_reg(rrbgp_pkg::CFG_HOST_BYTES,
                          ($urandom & 32'hFFFF_0000) | 32'(host_v));
                write_reg(rrbgp_pkg::CFG_BANDWIDTH, bw_v);
                xfer_est = (cfg_bw == 0) ? 64'd0
                         : (64'(cfg_wire) * 64'd1000000) / 64'(cfg_bw);

                for (i = 0; i < SEG_ITEMS; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        sim_clock = {$urandom, $urandom};
                    end else if (r < 18) begin
                        // right at the end of the busy window
                        sim_clock = pace_busy_until - 64'($urandom_range(0, 1));
                    end else if (r >= 25) begin
                        sim_clock = sim_clock + {$urandom, $urandom} % (2 * xfer_est + 64'd4);
                    end
                    r = $urandom_range(0, 99);
                    if (r < 10)      mask_v = 16'h0000;
                    else if (r < 40) mask_v = 16'h0001 << $urandom_range(0, 15);
                    else             mask_v = 16'($urandom);
                    if (p == 2 && s == 0 && i == 10) hold_req <= 1'b1;
                    push_event(sim_clock, mask_v, ($urandom_range(0, 99) < 15), 1'b0, NO_RES);
                end
                settle();
            end
        end

        repeat (60) @(posedge i_clk);
        err_cnt += grant_exp_q.size();
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
